// ===== rtl/core/round_robin_thread_scheduler_unit_defines.svh =====
// Assertion macros shared by the checker of the round robin thread scheduler.
// Depends on nothing; guarded against double inclusion.
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_UNIT_DEFINES_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_UNIT_DEFINES_SVH
// Implication checked at every clock edge outside reset.
`define RRTS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define RRTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== rtl/core/rrts_pkg.sv =====
// Types and codes of the round robin thread scheduler.
// Depends on nothing.
package rrts_pkg;
   typedef enum logic [2:0] {
      ST_UNUSED = 3'd0, ST_RUNNING = 3'd1, ST_EXITED = 3'd2,
      ST_WAITING = 3'd3, ST_SUSPEND = 3'd4, ST_SLEEP = 3'd5
   } slot_state_type;

   typedef enum logic [2:0] {
      FN_CREATE = 3'd0, FN_EXIT = 3'd1, FN_SUSPEND = 3'd2, FN_RESUME = 3'd3,
      FN_KILL = 3'd4, FN_SLEEP = 3'd5, FN_YIELD = 3'd6, FN_NONE = 3'd7
   } func_type;

   typedef enum logic [2:0] {
      RES_OK = 3'd0, RES_REJECT = 3'd1, RES_DEADLOCK = 3'd2,
      RES_FINISHED = 3'd3, RES_NONE = 3'd4
   } res_type;

   typedef enum logic [2:0] {
      FSM_IDLE, FSM_PREP, FSM_SCAN, FSM_SWITCH, FSM_MASK, FSM_DONE
   } fsm_type;

   typedef struct packed {
      logic [2:0]  func;
      logic [4:0]  target_id;
      logic [15:0] sleep_ms;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [4:0]  result_id;
      logic [4:0]  current_id;
      logic        switched;
      logic [31:0] suspended_mask;
   } rsp_type;

   localparam int unsigned TIME_SLICE_RESET = 200;
   localparam int unsigned MASK_WIDTH = 32;
endpackage

// ===== rtl/core/rrts_if.sv =====
// Valid/ready channel carrying one word of a given payload type.
// Depends on rrts_pkg for the payload types.
interface rrts_if #(parameter type payload_type = rrts_pkg::req_type) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/round_robin_thread_scheduler_unit.sv =====
// Round robin thread scheduler: slot table, command sequencer and result register.
// Depends on rrts_pkg and rrts_if.
//
// Usage: commands arrive as words on req (func, target_id, sleep_ms, now_ms);
// each gives exactly one word on rsp. The user must write the time slice
// register on csr_we/csr_wdata only while idle; the block does not check it.
// Timing: one command at a time. A scheduling command (exit, suspend, sleep,
// yield) passes a prepare step, walks the slots one per cycle from the slot
// after the current one, a switch step when it finds a slot to run, a pick
// write when one is pending and a mask pass over the slots; create walks
// from slot zero and then goes to the mask pass. Resume, kill and code seven
// skip the scan. The result word is registered in the done state. The slot
// table is a state memory and a deadline memory that share a single read
// address and a single write address; the walk over them sets the rate.
// Reset: slot zero runs, all others are unused, time slice is 200 ms. The
// memory has valid bits cleared by reset, so no clearing pass is needed.
// A stalled receiver holds the result word; no new command is taken until
// it has been delivered.
module round_robin_thread_scheduler_unit #(
   parameter int SLOT_COUNT = 32
) (
   input  logic        clock,
   input  logic        reset,
   rrts_if.sink        req,
   rrts_if.source      rsp,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);
   localparam int IW = $clog2(SLOT_COUNT);
   localparam int CW = $clog2(SLOT_COUNT + 1);

   rrts_pkg::fsm_type state_ff, state_in;
   rrts_pkg::req_type cmd_ff;
   logic [15:0]   slice_ff;
   logic [31:0]   slice_start_ff, slice_start_in;
   logic [IW-1:0] cur_ff, cur_in, old_ff;
   logic [IW-1:0] idx_ff, idx_in, pick_ff, pick_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          sleeper_ff, sleeper_in, create_ff, create_in;
   logic [2:0]    status_ff, status_in;
   logic [4:0]    rid_ff, rid_in;
   logic [31:0]   mask_ff, mask_in;
   rrts_pkg::rsp_type out_ff;
   logic          out_valid_ff;

   logic [2:0]    st_mem [SLOT_COUNT];
   logic [31:0]   dl_mem [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] vld_ff;

   // Single write port for the state table, deadline written separately.
   logic          st_we, dl_we;
   logic [IW-1:0] st_wa;
   logic [2:0]    st_wd;
   logic [31:0]   dl_wd;

   // Combinational read at idx_ff: the read of one entry per cycle is the shared path.
   logic [2:0]  rd_st;
   logic [31:0] rd_dl, dnow;
   logic        past;
   logic [2:0]  eff_st;
   logic        tgt_ok;
   logic [2:0]  tgt_st;
   logic [IW-1:0] tgt_idx;

   always_comb begin
      rd_st = vld_ff[idx_ff] ? st_mem[idx_ff] :
              ((idx_ff == '0) ? 3'(rrts_pkg::ST_RUNNING) : 3'(rrts_pkg::ST_UNUSED));
      rd_dl = vld_ff[idx_ff] ? dl_mem[idx_ff] : 32'd0;
      dnow  = cmd_ff.now_ms - rd_dl;
      past  = (dnow != 32'd0) && !dnow[31];
      eff_st = (rd_st == 3'(rrts_pkg::ST_SLEEP) && past) ? 3'(rrts_pkg::ST_WAITING) : rd_st;
      tgt_ok = ({27'd0, cmd_ff.target_id} < 32'(SLOT_COUNT));
      tgt_idx = IW'(cmd_ff.target_id);
      tgt_st = tgt_ok ? rd_st : 3'(rrts_pkg::ST_UNUSED);
   end

   always_ff @(posedge clock) begin
      if (st_we) st_mem[st_wa] <= st_wd;
      if (dl_we) dl_mem[st_wa] <= dl_wd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (st_we || dl_we) begin
         vld_ff[st_wa] <= 1'b1;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rrts_pkg::FSM_IDLE:   if (req.valid && !out_valid_ff) state_in = rrts_pkg::FSM_PREP;
         rrts_pkg::FSM_PREP: begin
            case (rrts_pkg::func_type'(cmd_ff.func))
               rrts_pkg::FN_CREATE, rrts_pkg::FN_EXIT, rrts_pkg::FN_SUSPEND,
               rrts_pkg::FN_SLEEP, rrts_pkg::FN_YIELD: state_in = rrts_pkg::FSM_SCAN;
               default: state_in = rrts_pkg::FSM_MASK;
            endcase
         end
         rrts_pkg::FSM_SCAN: begin
            if (create_ff) begin
               if (eff_st == 3'(rrts_pkg::ST_UNUSED) || eff_st == 3'(rrts_pkg::ST_EXITED) ||
                   cnt_ff == CW'(SLOT_COUNT - 1))
                  state_in = rrts_pkg::FSM_MASK;
            end else if (eff_st == 3'(rrts_pkg::ST_WAITING) ||
                         eff_st == 3'(rrts_pkg::ST_RUNNING)) begin
               state_in = rrts_pkg::FSM_SWITCH;
            end else if (idx_ff == cur_ff) begin
               state_in = rrts_pkg::FSM_MASK;
            end
         end
         rrts_pkg::FSM_SWITCH: state_in = rrts_pkg::FSM_MASK;
         rrts_pkg::FSM_MASK:   if (cnt_ff == CW'(SLOT_COUNT - 1)) state_in = rrts_pkg::FSM_DONE;
         rrts_pkg::FSM_DONE:   state_in = rrts_pkg::FSM_IDLE;
         default:              state_in = rrts_pkg::FSM_IDLE;
      endcase
   end

   // Datapath and memory writes.
   always_comb begin
      idx_in = idx_ff; cnt_in = cnt_ff; pick_in = pick_ff; cur_in = cur_ff;
      sleeper_in = sleeper_ff; create_in = create_ff; status_in = status_ff;
      rid_in = rid_ff; mask_in = mask_ff; slice_start_in = slice_start_ff;
      st_we = 1'b0; dl_we = 1'b0; st_wa = idx_ff; st_wd = rd_st; dl_wd = 32'd0;
      case (state_ff)
         rrts_pkg::FSM_IDLE: begin
            idx_in = cur_ff;
            // Resume and kill read their target slot in the prepare cycle.
            if (req.valid && !out_valid_ff &&
                (req.data.func == 3'(rrts_pkg::FN_RESUME) ||
                 req.data.func == 3'(rrts_pkg::FN_KILL)))
               idx_in = IW'(req.data.target_id);
         end
         rrts_pkg::FSM_PREP: begin
            status_in = 3'(rrts_pkg::RES_OK); rid_in = '0; sleeper_in = 1'b0;
            cnt_in = '0; create_in = 1'b0; mask_in = '0;
            idx_in = (cur_ff == IW'(SLOT_COUNT - 1)) ? '0 : cur_ff + 1'b1;
            st_wa = cur_ff;
            case (rrts_pkg::func_type'(cmd_ff.func))
               rrts_pkg::FN_CREATE: begin
                  create_in = 1'b1; idx_in = '0;
               end
               rrts_pkg::FN_EXIT: begin
                  st_we = 1'b1; st_wd = 3'(rrts_pkg::ST_EXITED);
               end
               rrts_pkg::FN_SUSPEND: begin
                  st_we = 1'b1; st_wd = 3'(rrts_pkg::ST_SUSPEND);
               end
               rrts_pkg::FN_SLEEP: begin
                  st_we = 1'b1; st_wd = 3'(rrts_pkg::ST_SLEEP);
                  dl_we = 1'b1; dl_wd = cmd_ff.now_ms + {16'd0, cmd_ff.sleep_ms};
               end
               rrts_pkg::FN_YIELD: ;
               default: ;
            endcase
            // Resume and kill: idx_ff holds the target, loaded when the word was taken.
            if (cmd_ff.func == 3'(rrts_pkg::FN_RESUME) ||
                cmd_ff.func == 3'(rrts_pkg::FN_KILL)) begin
               st_wa = tgt_idx; idx_in = '0;
               if (cmd_ff.func == 3'(rrts_pkg::FN_RESUME)) begin
                  if (tgt_ok && tgt_st == 3'(rrts_pkg::ST_SUSPEND)) begin
                     st_we = 1'b1; st_wd = 3'(rrts_pkg::ST_WAITING);
                  end else status_in = 3'(rrts_pkg::RES_REJECT);
               end else begin
                  if (tgt_ok && tgt_st != 3'(rrts_pkg::ST_EXITED) &&
                      tgt_st != 3'(rrts_pkg::ST_UNUSED) &&
                      tgt_st != 3'(rrts_pkg::ST_RUNNING)) begin
                     st_we = 1'b1; st_wd = 3'(rrts_pkg::ST_EXITED);
                     rid_in = cmd_ff.target_id;
                  end else status_in = 3'(rrts_pkg::RES_REJECT);
               end
            end else if (cmd_ff.func == 3'(rrts_pkg::FN_NONE)) begin
               status_in = 3'(rrts_pkg::RES_REJECT); idx_in = '0;
            end
         end
         rrts_pkg::FSM_SCAN: begin
            if (create_ff) begin
               if (eff_st == 3'(rrts_pkg::ST_UNUSED) || eff_st == 3'(rrts_pkg::ST_EXITED)) begin
                  st_we = 1'b1; st_wd = 3'(rrts_pkg::ST_WAITING);
                  rid_in = 5'(idx_ff); idx_in = '0; cnt_in = '0;
               end else if (cnt_ff == CW'(SLOT_COUNT - 1)) begin
                  status_in = 3'(rrts_pkg::RES_REJECT); idx_in = '0; cnt_in = '0;
               end else begin
                  idx_in = idx_ff + 1'b1; cnt_in = cnt_ff + 1'b1;
               end
            end else begin
               if (eff_st != rd_st) begin
                  st_we = 1'b1; st_wd = eff_st;
               end
               if (eff_st == 3'(rrts_pkg::ST_WAITING) || eff_st == 3'(rrts_pkg::ST_RUNNING)) begin
                  pick_in = idx_ff; idx_in = cur_ff;
               end else if (idx_ff == cur_ff) begin
                  if (sleeper_ff || eff_st == 3'(rrts_pkg::ST_SLEEP))
                     status_in = 3'(rrts_pkg::RES_NONE);
                  else if (eff_st == 3'(rrts_pkg::ST_SUSPEND))
                     status_in = 3'(rrts_pkg::RES_DEADLOCK);
                  else status_in = 3'(rrts_pkg::RES_FINISHED);
                  idx_in = '0; cnt_in = '0;
               end else begin
                  if (eff_st == 3'(rrts_pkg::ST_EXITED)) begin
                     st_we = 1'b1; st_wd = 3'(rrts_pkg::ST_UNUSED);
                  end
                  if (eff_st == 3'(rrts_pkg::ST_SLEEP)) sleeper_in = 1'b1;
                  idx_in = (idx_ff == IW'(SLOT_COUNT - 1)) ? '0 : idx_ff + 1'b1;
               end
            end
         end
         rrts_pkg::FSM_SWITCH: begin
            // idx_ff is the current slot; its state is now final for this command.
            if ((cmd_ff.now_ms - slice_start_ff) >= {16'd0, slice_ff} ||
                rd_st == 3'(rrts_pkg::ST_EXITED) || rd_st == 3'(rrts_pkg::ST_SUSPEND) ||
                rd_st == 3'(rrts_pkg::ST_SLEEP)) begin
               if (rd_st == 3'(rrts_pkg::ST_RUNNING) && pick_ff != cur_ff) begin
                  st_we = 1'b1; st_wa = cur_ff; st_wd = 3'(rrts_pkg::ST_WAITING);
               end else if (pick_ff != cur_ff || rd_st != 3'(rrts_pkg::ST_RUNNING)) begin
                  st_we = 1'b1; st_wa = pick_ff; st_wd = 3'(rrts_pkg::ST_RUNNING);
               end
               cur_in = pick_ff; slice_start_in = cmd_ff.now_ms;
            end
            idx_in = pick_ff; cnt_in = '0;
         end
         rrts_pkg::FSM_MASK: begin
            // A pending pick write, when the old slot took the write port.
            if (cur_ff != old_ff && idx_ff == cur_ff && rd_st != 3'(rrts_pkg::ST_RUNNING) &&
                cnt_ff == '0) begin
               st_we = 1'b1; st_wd = 3'(rrts_pkg::ST_RUNNING);
               idx_in = '0;
            end else begin
               if (cnt_ff == '0 && idx_ff != '0) idx_in = '0;
               else begin
                  if (int'(idx_ff) < rrts_pkg::MASK_WIDTH && rd_st == 3'(rrts_pkg::ST_SUSPEND))
                     mask_in[5'(idx_ff)] = 1'b1;
                  else if (int'(idx_ff) < rrts_pkg::MASK_WIDTH)
                     mask_in[5'(idx_ff)] = 1'b0;
                  idx_in = (idx_ff == IW'(SLOT_COUNT - 1)) ? '0 : idx_ff + 1'b1;
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   // The mask stage counts only real entry visits; extra cycles above hold cnt at zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rrts_pkg::FSM_IDLE;
         cur_ff <= '0; old_ff <= '0; slice_start_ff <= '0;
         slice_ff <= 16'(rrts_pkg::TIME_SLICE_RESET);
         out_valid_ff <= 1'b0; idx_ff <= '0; cnt_ff <= '0; create_ff <= 1'b0;
         sleeper_ff <= 1'b0;
      end else begin
         state_ff <= (state_ff == rrts_pkg::FSM_MASK && cnt_in != CW'(SLOT_COUNT) &&
                      state_in == rrts_pkg::FSM_DONE && cnt_ff != CW'(SLOT_COUNT - 1))
                     ? state_ff : state_in;
         cur_ff <= cur_in; slice_start_ff <= slice_start_in;
         idx_ff <= idx_in; cnt_ff <= cnt_in; create_ff <= create_in;
         sleeper_ff <= sleeper_in;
         if (csr_we) slice_ff <= csr_wdata;
         if (state_ff == rrts_pkg::FSM_IDLE && req.valid && !out_valid_ff) old_ff <= cur_ff;
         if (state_ff == rrts_pkg::FSM_DONE) out_valid_ff <= 1'b1;
         else if (rsp.ready) out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == rrts_pkg::FSM_IDLE && req.valid && !out_valid_ff) cmd_ff <= req.data;
      status_ff <= status_in; rid_ff <= rid_in; pick_ff <= pick_in; mask_ff <= mask_in;
      if (state_ff == rrts_pkg::FSM_DONE) begin
         out_ff.status <= status_ff;
         out_ff.result_id <= (status_ff == 3'(rrts_pkg::RES_OK)) ? rid_ff : 5'd0;
         out_ff.current_id <= 5'(cur_ff);
         out_ff.switched <= (cur_ff != old_ff);
         out_ff.suspended_mask <= mask_ff;
      end
   end

   assign req.ready = (state_ff == rrts_pkg::FSM_IDLE) && !out_valid_ff;
   assign rsp.valid = out_valid_ff;
   assign rsp.data  = out_ff;
endmodule

// ===== rtl/core/rrts_checker.sv =====
// Port-level checks for the round robin thread scheduler, bound to the scheduler module.
// Depends on rrts_pkg and the defines header.
`include "round_robin_thread_scheduler_unit_defines.svh"
module rrts_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input rrts_pkg::rsp_type rsp_data
);
   `RRTS_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready, "second word taken during a command")
   `RRTS_ASSERT_IMP(a_no_take_while_full, clock, reset, rsp_valid, !req_ready, "word taken while a result waits")
   `RRTS_ASSERT_IMP(a_status_range, clock, reset, rsp_valid, rsp_data.status <= 3'(rrts_pkg::RES_NONE), "status out of range")
   `RRTS_ASSERT_IMP(a_rid_zero, clock, reset, rsp_valid && rsp_data.status != 3'(rrts_pkg::RES_OK), rsp_data.result_id == 5'd0, "result id set on failure")
   `RRTS_ASSERT_NEXT(a_hold_while_stalled, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result word changed while stalled")
endmodule

bind round_robin_thread_scheduler_unit rrts_checker u_rrts_checker (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data));
